@@ hw/rtl/mctt_pkg.sv @@
// Shared types and constants of the multi-channel timer table.
package mctt_pkg;

   // Function codes carried on req_tuser.
   localparam logic [1:0] OP_SET   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Result kinds carried in rsp_tdata.
   localparam logic [1:0] KIND_SET_OK  = 2'd0;
   localparam logic [1:0] KIND_REFUSED = 2'd1;
   localparam logic [1:0] KIND_FIRED   = 2'd2;

   // Only this many firings of one tick are reported.
   localparam int MAX_RESULTS = 16;
   localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

   localparam int TIME_W = 32;
   localparam int ID_W   = 31;
   localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

   // Port widths: input data is duration, periodic, target_id, elapsed.
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 40;

   // One timer entry as held in the table memory.
   typedef struct packed {
      logic [TIME_W-1:0] remaining;
      logic [TIME_W-1:0] interval;
      logic              periodic;
      logic [ID_W-1:0]   ident;
   } entry_type;

   // Request into the shared remainder unit.
   typedef struct packed {
      logic              start;
      logic [TIME_W-1:0] dividend;
      logic [TIME_W-1:0] divisor;
   } div_req_type;

   // Status back from the shared remainder unit.
   typedef struct packed {
      logic              done;
      logic [TIME_W-1:0] remainder;
   } div_rsp_type;

endpackage

@@ hw/rtl/mctt_table.sv @@
// Timer entry memory with one write port and one registered read port.
module mctt_table #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  mctt_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output mctt_pkg::entry_type rd_data
);

   mctt_pkg::entry_type mem_ff [DEPTH];
   mctt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/mctt_divider.sv @@
// Restoring remainder unit that retires one quotient bit per cycle.
module mctt_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  mctt_pkg::div_req_type req,
   output mctt_pkg::div_rsp_type rsp
);

   localparam int W  = mctt_pkg::TIME_W;
   localparam int SW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [SW-1:0] step_ff, step_in;
   logic [W:0]    rem_ff, rem_in;
   logic [W-1:0]  num_ff, num_in;
   logic [W-1:0]  den_ff, den_in;
   logic [W:0]    shifted;
   logic [W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      shifted = {rem_ff[W-1:0], num_ff[W-1]};
      trial   = shifted - {1'b0, den_ff};
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         num_in  = req.dividend;
         den_in  = req.divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits W bits.
         rem_in  = trial[W] ? shifted : trial;
         num_in  = {num_ff[W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == SW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff[W-1:0];

endmodule

@@ hw/rtl/multi_channel_timer_table.sv @@
// Top level of the multi-channel timer table: sequencer, flags and result register.
//
//   Channel   Direction  Handshake             Contents
//   req_*     in         req_tvalid/req_tready tuser: func; tdata: duration, periodic,
//                                              target_id, elapsed
//   rsp_*     out        rsp_tvalid/rsp_tready tdata: timer_id, kind; tlast: last
//
// A set item waits in the reply state for the result register. A clear item walks the
// table, reading each entry in a fetch state and an examine state. A tick item walks it
// the same way, and each periodic entry that fires also waits for the shared remainder
// unit that catches it up by whole intervals. Reset is synchronous and active high; it
// empties the table and sets the next id to one, with no clearing pass. While the result
// register is full and not taken, the sequencer waits at the next result it must deliver.
//
// Time is unsigned fixed point with one unit of 100 microseconds, so no rounding occurs.
module multi_channel_timer_table #(
   parameter int TIMERS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // From bit 0 up: duration[31:0], periodic, target_id[30:0], elapsed[31:0].
   input  logic [mctt_pkg::REQ_DATA_W-1:0] req_tdata,
   // From bit 0 up: func[1:0].
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // From bit 0 up: timer_id[30:0], kind[1:0], then zero fill.
   output logic [mctt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);

   localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam int CW = $clog2(TIMERS + 1);
   localparam int TW = mctt_pkg::TIME_W;
   localparam int DW = mctt_pkg::ID_W;
   localparam int FW = mctt_pkg::FIRE_W;

   // Sequencer states with one-hot codes.
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_REPLY = 6'b000010,
      ST_FETCH = 6'b000100,
      ST_EXAM  = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_FLUSH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Control state.
   logic [1:0]        op_ff, op_in;
   logic [CW-1:0]     count_ff, count_in;     // live entries form a prefix of the table
   logic [CW-1:0]     idx_ff, idx_in;         // entry being read during a walk
   logic [CW-1:0]     wr_ptr_ff, wr_ptr_in;   // compaction target during a tick
   logic [FW-1:0]     fired_ff, fired_in;     // firings reported so far in this tick
   logic              pend_valid_ff, pend_valid_in;
   logic [DW-1:0]     next_id_ff, next_id_in;
   logic [TIMERS-1:0] cancel_ff, cancel_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload state.
   logic [TW-1:0] dur_ff;
   logic          per_ff;
   logic [DW-1:0] target_ff;
   logic [TW-1:0] elapsed_ff;
   logic [DW-1:0] pend_id_ff, pend_id_in;
   logic [DW-1:0] rsp_id_ff, rsp_id_in;
   logic [1:0]    rsp_kind_ff, rsp_kind_in;
   logic          rsp_last_ff, rsp_last_in;

   // Table and remainder unit connections.
   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   mctt_pkg::entry_type   wr_data;
   mctt_pkg::entry_type   ent;
   mctt_pkg::div_req_type div_req;
   mctt_pkg::div_rsp_type div_rsp;

   logic          accept;
   logic          out_free;
   logic          fires;
   logic [TW:0]   left;
   logic [TW-1:0] deficit;
   logic [CW-1:0] idx_next;
   logic          walk_end;
   logic          want_emit;

   mctt_table #(
      .DEPTH (TIMERS),
      .AW    (IW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (ent)
   );

   mctt_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Stored remaining times are always in 0 .. 2^32-1, so the time overdue after a tick
   // also fits 32 bits and one 33-bit subtract decides whether the entry fires.
   assign left      = {1'b0, ent.remaining} - {1'b0, elapsed_ff};
   assign fires     = left[TW] || (left[TW-1:0] == '0);
   assign deficit   = elapsed_ff - ent.remaining;
   assign idx_next  = idx_ff + 1'b1;
   assign walk_end  = (idx_next == count_ff);
   assign want_emit = (fired_ff < FW'(mctt_pkg::MAX_RESULTS));

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      wr_ptr_in     = wr_ptr_ff;
      fired_in      = fired_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      next_id_in    = next_id_ff;
      cancel_in     = cancel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_id_in     = rsp_id_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_last_in   = rsp_last_ff;

      wr_en             = 1'b0;
      wr_addr           = wr_ptr_ff[IW-1:0];
      wr_data           = ent;
      div_req.start     = 1'b0;
      div_req.dividend  = deficit;
      div_req.divisor   = ent.interval;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_tuser;
               idx_in    = '0;
               wr_ptr_in = '0;
               fired_in  = '0;
               case (req_tuser)
                  mctt_pkg::OP_SET: begin
                     state_in = ST_REPLY;
                  end
                  mctt_pkg::OP_CLEAR, mctt_pkg::OP_TICK: begin
                     state_in = (count_ff == '0) ? ST_FLUSH : ST_FETCH;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
               if (count_ff == CW'(TIMERS)) begin
                  rsp_id_in   = '0;
                  rsp_kind_in = mctt_pkg::KIND_REFUSED;
               end else begin
                  wr_en             = 1'b1;
                  wr_addr           = count_ff[IW-1:0];
                  wr_data.remaining = dur_ff;
                  wr_data.interval  = (dur_ff == '0) ? TW'(1) : dur_ff;
                  wr_data.periodic  = per_ff;
                  wr_data.ident     = next_id_ff;
                  cancel_in[count_ff[IW-1:0]] = 1'b0;
                  count_in    = count_ff + 1'b1;
                  next_id_in  = (next_id_ff == mctt_pkg::ID_MAX) ? DW'(1)
                                                                 : next_id_ff + 1'b1;
                  rsp_id_in   = next_id_ff;
                  rsp_kind_in = mctt_pkg::KIND_SET_OK;
               end
            end
         end

         ST_FETCH: begin
            // The table read of entry idx lands in the read register this cycle.
            state_in = ST_EXAM;
         end

         ST_EXAM: begin
            if (op_ff == mctt_pkg::OP_CLEAR) begin
               if (ent.ident == target_ff) begin
                  cancel_in[idx_ff[IW-1:0]] = 1'b1;
               end
               idx_in   = idx_next;
               state_in = walk_end ? ST_FLUSH : ST_FETCH;
            end else if (cancel_ff[idx_ff[IW-1:0]]) begin
               // Cancelled entries are skipped and dropped by the compaction.
               idx_in   = idx_next;
               state_in = walk_end ? ST_FLUSH : ST_FETCH;
            end else if (!fires) begin
               wr_en             = 1'b1;
               wr_data.remaining = left[TW-1:0];
               wr_ptr_in         = wr_ptr_ff + 1'b1;
               idx_in            = idx_next;
               state_in          = walk_end ? ST_FLUSH : ST_FETCH;
            end else if (!(want_emit && pend_valid_ff && !out_free)) begin
               // A firing is held back one step so that the final one can carry last.
               if (want_emit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_id_in    = pend_id_ff;
                     rsp_kind_in  = mctt_pkg::KIND_FIRED;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_id_in    = ent.ident;
                  fired_in      = fired_ff + 1'b1;
               end
               if (ent.periodic) begin
                  div_req.start = 1'b1;
                  state_in      = ST_DIV;
               end else begin
                  idx_in   = idx_next;
                  state_in = walk_end ? ST_FLUSH : ST_FETCH;
               end
            end
         end

         ST_DIV: begin
            if (div_rsp.done) begin
               // Adding whole intervals until positive leaves interval - (overdue mod interval).
               wr_en             = 1'b1;
               wr_data.remaining = ent.interval - div_rsp.remainder;
               wr_ptr_in         = wr_ptr_ff + 1'b1;
               idx_in            = idx_next;
               state_in          = walk_end ? ST_FLUSH : ST_FETCH;
            end
         end

         ST_FLUSH: begin
            if (op_ff != mctt_pkg::OP_TICK) begin
               state_in = ST_IDLE;
            end else if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = pend_id_ff;
                  rsp_kind_in  = mctt_pkg::KIND_FIRED;
                  rsp_last_in  = 1'b1;
               end
               pend_valid_in = 1'b0;
               count_in      = wr_ptr_ff;
               cancel_in     = '0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= mctt_pkg::OP_SET;
         count_ff      <= '0;
         idx_ff        <= '0;
         wr_ptr_ff     <= '0;
         fired_ff      <= '0;
         pend_valid_ff <= 1'b0;
         next_id_ff    <= DW'(1);
         cancel_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         wr_ptr_ff     <= wr_ptr_in;
         fired_ff      <= fired_in;
         pend_valid_ff <= pend_valid_in;
         next_id_ff    <= next_id_in;
         cancel_ff     <= cancel_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dur_ff     <= req_tdata[31:0];
         per_ff     <= req_tdata[32];
         target_ff  <= req_tdata[63:33];
         elapsed_ff <= req_tdata[95:64];
      end
      pend_id_ff  <= pend_id_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(mctt_pkg::RSP_DATA_W - DW - 2){1'b0}}, rsp_kind_ff, rsp_id_ff};
   assign rsp_tlast  = rsp_last_ff;

   // The table never holds more entries than it has slots.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(TIMERS))
      else $error("timer table count exceeds its depth");

   // A finished tick leaves no cancelled entry behind.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) && (op_ff == mctt_pkg::OP_TICK) && (state_in == ST_IDLE)
      |=> cancel_ff == '0)
      else $error("cancelled entries survived a tick");

   // The remainder unit only reports while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset) div_rsp.done |-> state_ff == ST_DIV)
      else $error("remainder unit finished outside a catch-up step");

   // No more firings are reported in one tick than the result limit.
   assert property (@(posedge clock) disable iff (reset)
      fired_ff <= FW'(mctt_pkg::MAX_RESULTS))
      else $error("too many firings reported in one tick");

endmodule

@@ tb/mctt_checker.sv @@
// Checker for the multi-channel timer table: predicts every result and compares it.
module mctt_checker #(
   parameter int TIMERS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [mctt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                      req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [mctt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tlast,
   output int                              failures,
   output int                              pending,
   output int                              items_seen,
   output int                              results_seen,
   output int                              fired_seen,
   output int                              refused_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import mctt_pkg::*;

   typedef struct packed {
      logic [ID_W-1:0] ident;
      logic [1:0]      kind;
      logic            last;
   } report_t;

   // Private copy of the timer table, kept in creation order.
   logic                     t_live    [TIMERS];
   logic                     t_dropped [TIMERS];
   logic signed [TIME_W+1:0] t_left    [TIMERS];
   logic [TIME_W-1:0]        t_period  [TIMERS];
   logic                     t_rearm   [TIMERS];
   logic [ID_W-1:0]          t_id      [TIMERS];
   logic [ID_W-1:0]          id_next;

   report_t owed_reports[$];
   int      fail_count;
   int      item_count;
   int      result_count;
   int      fired_count;
   int      refused_count;

   function automatic report_t make_report(logic [ID_W-1:0] ident, logic [1:0] kind);
      report_t r;
      r.ident = ident;
      r.kind  = kind;
      r.last  = 1'b0;
      return r;
   endfunction

   task automatic apply_timer_command(input logic [1:0] func,
                                      input logic [REQ_DATA_W-1:0] data);
      logic [TIME_W-1:0] duration;
      logic              periodic;
      logic [ID_W-1:0]   target;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W+1:0] deficit;
      logic [TIME_W+1:0] step;
      report_t           burst[$];
      int                free_slot;
      int                i;
      int                w;
      duration = data[TIME_W-1:0];
      periodic = data[TIME_W];
      target   = data[TIME_W+ID_W:TIME_W+1];
      elapsed  = data[2*TIME_W+ID_W:TIME_W+ID_W+1];
      case (func)
         OP_SET: begin
            free_slot = -1;
            for (i = 0; i < TIMERS; i++) begin
               if (!t_live[i] && free_slot < 0) free_slot = i;
            end
            if (free_slot < 0) begin
               burst.insert(burst.size(), make_report('0, KIND_REFUSED));
            end else begin
               t_live[free_slot]    = 1'b1;
               t_dropped[free_slot] = 1'b0;
               t_left[free_slot]    = {2'b00, duration};
               t_period[free_slot]  = (duration == '0) ? TIME_W'(1) : duration;
               t_rearm[free_slot]   = periodic;
               t_id[free_slot]      = id_next;
               burst.insert(burst.size(), make_report(id_next, KIND_SET_OK));
               id_next = (id_next == ID_MAX) ? ID_W'(1) : id_next + 1'b1;
            end
         end
         OP_CLEAR: begin
            for (i = 0; i < TIMERS; i++) begin
               if (t_live[i] && t_id[i] == target) t_dropped[i] = 1'b1;
            end
         end
         OP_TICK: begin
            for (i = 0; i < TIMERS; i++) begin
               if (t_live[i] && !t_dropped[i]) begin
                  t_left[i] = t_left[i] - {2'b00, elapsed};
                  if (t_left[i] <= 0) begin
                     if (burst.size() < MAX_RESULTS) begin
                        burst.insert(burst.size(), make_report(t_id[i], KIND_FIRED));
                     end
                     if (t_rearm[i]) begin
                        // Catch up by whole intervals until the time left is positive.
                        deficit   = -t_left[i];
                        step      = {2'b00, t_period[i]};
                        t_left[i] = step - (deficit % step);
                     end else begin
                        t_dropped[i] = 1'b1;
                     end
                  end
               end
            end
            // Squeeze out cancelled and expired one-shot entries without disturbing the order.
            w = 0;
            for (i = 0; i < TIMERS; i++) begin
               if (t_live[i] && !t_dropped[i]) begin
                  t_left[w]    = t_left[i];
                  t_period[w]  = t_period[i];
                  t_rearm[w]   = t_rearm[i];
                  t_id[w]      = t_id[i];
                  t_live[w]    = 1'b1;
                  t_dropped[w] = 1'b0;
                  w++;
               end
            end
            for (i = w; i < TIMERS; i++) begin
               t_live[i]    = 1'b0;
               t_dropped[i] = 1'b0;
            end
         end
         default: ;
      endcase
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[k]) owed_reports.insert(owed_reports.size(), burst[k]);
   endtask

   task automatic check_report();
      report_t                       want;
      logic [ID_W-1:0]               got_id;
      logic [1:0]                    got_kind;
      logic [RSP_DATA_W-1:ID_W+2]    got_fill;
      got_id   = rsp_tdata[ID_W-1:0];
      got_kind = rsp_tdata[ID_W+1:ID_W];
      got_fill = rsp_tdata[RSP_DATA_W-1:ID_W+2];
      result_count++;
      if (got_kind == KIND_FIRED) fired_count++;
      if (got_kind == KIND_REFUSED) refused_count++;
      if (owed_reports.size() == 0) begin
         $display("%t: unexpected result, got id %0d kind %0d last %0d",
                  $time, got_id, got_kind, rsp_tlast);
         fail_count++;
      end else begin
         want = owed_reports.pop_front();
         if (got_id !== want.ident || got_kind !== want.kind || rsp_tlast !== want.last ||
             got_fill !== '0) begin
            $display({"%t: result mismatch, expected id %0d kind %0d last %0d fill 0, ",
                      "got id %0d kind %0d last %0d fill %0h"},
                     $time, want.ident, want.kind, want.last,
                     got_id, got_kind, rsp_tlast, got_fill);
            fail_count++;
         end
      end
   endtask

   initial begin
      fail_count    = 0;
      item_count    = 0;
      result_count  = 0;
      fired_count   = 0;
      refused_count = 0;
      id_next       = ID_W'(1);
      for (int i = 0; i < TIMERS; i++) begin
         t_live[i]    = 1'b0;
         t_dropped[i] = 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         id_next = ID_W'(1);
         for (int i = 0; i < TIMERS; i++) begin
            t_live[i]    = 1'b0;
            t_dropped[i] = 1'b0;
         end
      end else begin
         if (req_tvalid && req_tready) begin
            item_count++;
            apply_timer_command(req_tuser, req_tdata);
         end
         if (rsp_tvalid && rsp_tready) check_report();
      end
      failures     <= fail_count;
      pending      <= owed_reports.size();
      items_seen   <= item_count;
      results_seen <= result_count;
      fired_seen   <= fired_count;
      refused_seen <= refused_count;
   end

endmodule

@@ tb/tb_multi_channel_timer_table.sv @@
// Testbench top for the multi-channel timer table: clock, reset, stimulus and verdict.
module tb_multi_channel_timer_table;
   timeunit 1ns;
   timeprecision 1ps;
   import mctt_pkg::*;

   localparam int TIMERS = 16;
   // The fourth function code is undefined; the block must ignore it.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Random items spread over four idling phases.
   localparam int RANDOM_ITEMS = 140;
   // Length of the long result hold-off that fills the block up.
   localparam int HOLD_CYCLES = 400;
   // Upper bound on any wait for outstanding results.
   localparam int DRAIN_LIMIT = 50000;
   // Settling wait, with margin for a tick with sixteen periodic catch-ups.
   localparam int SETTLE_CYCLES = 800;
   // Hard stop for the whole run, far beyond the slowest correct run.
   localparam longint LIMIT_NS = 64'd10_000_000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // From bit 0 up: duration[31:0], periodic, target_id[30:0], elapsed[31:0].
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // From bit 0 up: func[1:0].
   logic [1:0]            req_tuser  = OP_SET;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // From bit 0 up: timer_id[30:0], kind[1:0], then zero fill.
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // Idling controls: percentage of cycles the sender stays idle and the
   // receiver stalls. The hold flag is owned by the hold-off process below.
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic rsp_hold      = 1'b0;
   event hold_kick;

   // Number of set items offered so far; used to aim clear items at ids that
   // are likely to be in the table.
   int sets_offered = 0;

   int failures;
   int pending;
   int items_seen;
   int results_seen;
   int fired_seen;
   int refused_seen;

   multi_channel_timer_table #(
      .TIMERS(TIMERS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   mctt_checker #(
      .TIMERS(TIMERS)
   ) checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .failures     (failures),
      .pending      (pending),
      .items_seen   (items_seen),
      .results_seen (results_seen),
      .fired_seen   (fired_seen),
      .refused_seen (refused_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver takes results unless it is stalling at random or held off.
   always @(posedge clock) begin
      rsp_tready <= !reset && !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   // Long hold-off of the result channel. It counts its own cycles so that the
   // sender can keep offering items meanwhile and the block backs up.
   initial begin
      forever begin
         @(hold_kick);
         rsp_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   // Offers one item and returns at the edge where it was accepted. Valid is
   // only lowered when an idle gap follows, so a back-to-back item never sees
   // valid dropped and raised within the same time step.
   task automatic offer(input logic [1:0]        func,
                        input logic [TIME_W-1:0] duration,
                        input logic              periodic,
                        input logic [ID_W-1:0]   target,
                        input logic [TIME_W-1:0] elapsed);
      int gap;
      gap = 0;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {elapsed, target, periodic, duration};
      do @(posedge clock); while (!req_tready);
      if (func == OP_SET) sets_offered++;
   endtask

   // Stops offering and waits until every predicted result has come back.
   task automatic drain();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending != 0 && waited < DRAIN_LIMIT);
   endtask

   // One random item. Unused fields carry random bits, which the block must
   // ignore. Sets dominate so the table keeps filling up; ticks are mostly
   // short so that timers expire a few at a time, with occasional long jumps
   // that force deep periodic catch-up. Clears mostly name recent ids.
   task automatic offer_random(output bit counted);
      logic [TIME_W-1:0] duration;
      logic [TIME_W-1:0] elapsed;
      logic              periodic;
      logic [ID_W-1:0]   target;
      int                pick;
      int                hi;
      int                lo;
      duration = $urandom();
      elapsed  = $urandom();
      periodic = 1'($urandom_range(1));
      target   = ID_W'($urandom());
      pick     = $urandom_range(99);
      counted  = 1'b1;
      if (pick < 45) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: duration = $urandom_range(1, 40);
            6:                duration = '0;
            7, 8:             duration = $urandom_range(41, 2000);
            default:          ;
         endcase
         offer(OP_SET, duration, periodic, target, elapsed);
      end else if (pick < 60) begin
         hi = sets_offered + 1;
         lo = (hi > 24) ? hi - 24 : 1;
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: target = ID_W'($urandom_range(lo, hi));
            7:                   target = '0;
            8:                   target = ID_MAX;
            default:             ;
         endcase
         offer(OP_CLEAR, duration, periodic, target, elapsed);
      end else if (pick < 95) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: elapsed = $urandom_range(0, 30);
            7, 8:                elapsed = $urandom_range(31, 3000);
            default:             ;
         endcase
         offer(OP_TICK, duration, periodic, target, elapsed);
      end else begin
         offer(OP_UNUSED, duration, periodic, target, elapsed);
         counted = 1'b0;
      end
   endtask

   initial begin
      bit counted;
      int done;
      int phase;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening, no idling. A zero duration gets a one-unit interval
      // and expires at once; the longest duration is periodic.
      offer(OP_SET, '0, 1'b0, '0, '0);
      offer(OP_SET, 32'hFFFF_FFFF, 1'b1, ID_MAX, 32'hFFFF_FFFF);
      offer(OP_SET, 32'd1, 1'b1, '0, '0);
      // A tick of zero: the zero-duration entry fires with exactly nothing left.
      offer(OP_TICK, '0, 1'b0, '0, '0);
      // Clears of ids that do not exist change nothing and answer nothing.
      offer(OP_CLEAR, '0, 1'b0, ID_MAX, '0);
      offer(OP_CLEAR, '0, 1'b0, '0, '0);
      // The undefined function code with every data bit set must be ignored.
      offer(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, ID_MAX, 32'hFFFF_FFFF);
      // Fill the remaining fourteen slots with a mix of one-shot and periodic.
      for (int k = 0; k < 14; k++) begin
         offer(OP_SET, TIME_W'(3 + 5 * k), k[0], '0, '0);
      end
      // A cancelled entry still takes its slot until the next tick, so the
      // sets that follow are refused.
      offer(OP_CLEAR, '0, 1'b0, ID_W'(2), '0);
      offer(OP_SET, 32'd7, 1'b1, '0, '0);
      offer(OP_SET, 32'd9, 1'b0, '0, '0);
      // The longest tick: every live entry fires, periodic ones catch up by
      // billions of units, and the cancelled entry is dropped.
      offer(OP_TICK, '0, 1'b0, '0, 32'hFFFF_FFFF);
      offer(OP_TICK, '0, 1'b0, '0, 32'd1);
      drain();

      // Random phases. Each ends with the sender pausing until every result
      // has come back.
      done = 0;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct <= 0;
               rsp_stall_pct <= 0;
               // Hold results off while items keep streaming in back to back.
               -> hold_kick;
            end
            1: begin
               send_idle_pct <= 87;
               rsp_stall_pct <= 0;
            end
            2: begin
               send_idle_pct <= 0;
               rsp_stall_pct <= 87;
            end
            default: begin
               send_idle_pct <= 35;
               rsp_stall_pct <= 35;
            end
         endcase
         while (done < RANDOM_ITEMS * (phase + 1) / 4) begin
            offer_random(counted);
            if (counted) done++;
         end
         drain();
      end

      // Let any result-free work inside the block finish before judging.
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d items and %0d results, %0d of them firings and %0d refusals,",
               items_seen, results_seen, fired_seen, refused_seen);
      $display({"across free-running, sender-idle, receiver-stall and mixed phases ",
                "with a %0d-cycle hold."}, HOLD_CYCLES);
      if (failures == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         if (pending != 0) $display("%t: %0d expected results never arrived", $time, pending);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(LIMIT_NS);
      $display("%t: run timed out with %0d results outstanding", $time, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
